### hdl/pairwise_collision_velocity_resolver_core_assert.svh
// Assertion macros shared by the resolver RTL
`ifndef PAIRWISE_COLLISION_VELOCITY_RESOLVER_CORE_ASSERT_SVH
`define PAIRWISE_COLLISION_VELOCITY_RESOLVER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PCVR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pcvr assertion failed");
// next-cycle implication
`define PCVR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pcvr assertion failed");
`else
`define PCVR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PCVR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/pcvr_pkg.sv
// Shared types and constants of the collision velocity resolver
package pcvr_pkg;
  localparam int BODY_COUNT = 256;
  localparam int IDX_W      = $clog2(BODY_COUNT);
  localparam int DATA_W     = 32;
  localparam int REST_W     = 17;
  localparam int ONE_Q16    = 65536;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESOLVE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                     op;
    logic [IDX_W-1:0]         idx_a;
    logic [IDX_W-1:0]         idx_b;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0]        mass;
  } job_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_x;
    logic signed [DATA_W-1:0] a_y;
    logic signed [DATA_W-1:0] a_z;
    logic signed [DATA_W-1:0] b_x;
    logic signed [DATA_W-1:0] b_y;
    logic signed [DATA_W-1:0] b_z;
    logic                     sat;
  } res_t;
endpackage

### hdl/pcvr_if.sv
// Valid/ready channel interfaces for command input and result output
interface pcvr_in_if import pcvr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [7:0]               index_a;
  logic [7:0]               index_b;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] pos_z;
  logic signed [DATA_W-1:0] vel_x;
  logic signed [DATA_W-1:0] vel_y;
  logic signed [DATA_W-1:0] vel_z;
  logic [DATA_W-1:0]        mass;
  modport source (output valid, cmd, index_a, index_b, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, mass, input ready);
  modport sink (input valid, cmd, index_a, index_b, pos_x, pos_y, pos_z,
                vel_x, vel_y, vel_z, mass, output ready);
endinterface

interface pcvr_out_if import pcvr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] new_vel_a_x;
  logic signed [DATA_W-1:0] new_vel_a_y;
  logic signed [DATA_W-1:0] new_vel_a_z;
  logic signed [DATA_W-1:0] new_vel_b_x;
  logic signed [DATA_W-1:0] new_vel_b_y;
  logic signed [DATA_W-1:0] new_vel_b_z;
  logic                     saturated;
  modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
                  new_vel_b_x, new_vel_b_y, new_vel_b_z, saturated, input ready);
  modport sink (input valid, new_vel_a_x, new_vel_a_y, new_vel_a_z,
                new_vel_b_x, new_vel_b_y, new_vel_b_z, saturated, output ready);
endinterface

### hdl/pcvr_ram.sv
// Generic simple dual-port RAM with registered read
module pcvr_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hdl/pcvr_div.sv
// Radix-2 restoring unsigned divider, 64-bit dividend by 34-bit divisor
module pcvr_div import pcvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] nq_q;
  logic [33:0] rem_q, den_q;
  logic [34:0] trial;
  logic        fits;

  assign trial = {rem_q, nq_q[63]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? 34'(trial - {1'b0, den_q}) : trial[33:0];
      nq_q  <= {nq_q[62:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = nq_q;
endmodule

### hdl/pcvr_front.sv
// Front end: accept commands, drop no-ops, queue jobs for the back end
module pcvr_front import pcvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcvr_in_if.sink      in_i,
  output job_t         job_o,
  output logic         job_valid_o,
  input  logic         job_pop_i
);
  job_t              entries_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              accept, push;
  job_t              job_in;

  assign in_i.ready = count_q != QCNT_W'(QDEPTH);
  assign accept     = in_i.valid && in_i.ready;
  assign push       = accept && (cmd_e'(in_i.cmd) != CMD_NOP);

  always_comb begin
    job_in.op    = cmd_e'(in_i.cmd);
    job_in.idx_a = in_i.index_a[IDX_W-1:0];
    job_in.idx_b = in_i.index_b[IDX_W-1:0];
    job_in.pos_x = in_i.pos_x;
    job_in.pos_y = in_i.pos_y;
    job_in.pos_z = in_i.pos_z;
    job_in.vel_x = in_i.vel_x;
    job_in.vel_y = in_i.vel_y;
    job_in.vel_z = in_i.vel_z;
    job_in.mass  = in_i.mass;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (job_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, job_pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= job_in;
    end
  end

  assign job_o       = entries_q[rd_ptr_q];
  assign job_valid_o = count_q != '0;
endmodule

### hdl/pcvr_back.sv
// Back end: body tables, resolve sequencer and result register
`include "pairwise_collision_velocity_resolver_core_assert.svh"
module pcvr_back import pcvr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  logic [REST_W-1:0] restitution_i,
  output res_t              res_o,
  output logic              res_valid_o,
  input  logic              res_ready_i
);
  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_RDV  = 16'h0002,
    S_RDA  = 16'h0004,
    S_RDB  = 16'h0008,
    S_PREP = 16'h0010,
    S_NORM = 16'h0020,
    S_DOT  = 16'h0040,
    S_QS   = 16'h0080,
    S_QW   = 16'h0100,
    S_AW   = 16'h0200,
    S_BW   = 16'h0400,
    S_M1   = 16'h0800,
    S_M2   = 16'h1000,
    S_M3   = 16'h2000,
    S_WBA  = 16'h4000,
    S_WBB  = 16'h8000
  } state_e;

  localparam int POS_W = 4 * DATA_W;
  localparam int VEL_W = 3 * DATA_W;

  state_e state_q, state_d;
  logic   out_state;
  logic   is_read_q;

  logic [IDX_W-1:0] idx_a_q, idx_b_q, raddr, vel_waddr;
  logic             pos_we, vel_we;
  logic [POS_W-1:0] pos_rdata;
  logic [VEL_W-1:0] vel_rdata, vel_wdata;

  logic signed [31:0] pa_q [3];
  logic signed [31:0] pb_q [3];
  logic signed [31:0] va_q [3];
  logic signed [31:0] vb_q [3];
  logic signed [31:0] res_a_q [3];
  logic signed [31:0] res_b_q [3];
  logic [32:0]        mag_q [3];
  logic               neg_q [3];
  logic signed [32:0] w_q [3];
  logic signed [16:0] ds [3];
  logic [31:0]        ma_q, mb_q;
  logic [32:0]        msum_q, mx;
  logic [49:0]        prod_a_q, prod_b_q;
  logic [17:0]        one_e;
  logic signed [52:0] g_q;
  logic [52:0]        g_abs;
  logic [33:0]        dd_q;
  logic [1:0]         cnt_q;
  logic signed [31:0] q_q;
  logic [25:0]        fa_q, fb_q;
  logic signed [48:0] qds_q, qds_adj;
  logic signed [35:0] dl;
  logic signed [62:0] pa_prod_q, pb_prod_q, pa_adj, pb_adj;
  logic signed [49:0] wds;
  logic signed [33:0] ds2;
  logic signed [39:0] na, nb;
  logic [32:0]        ca, cb;
  logic               sat_q;
  logic signed [31:0] qmag;

  logic        div_start, div_busy, div_done;
  logic [63:0] div_num, div_quo;
  logic [33:0] div_den;

  res_t res_q;
  logic res_valid_q;

  function automatic logic [32:0] clip_f(input logic signed [39:0] v);
    logic [32:0] r;
    if (v > 40'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -40'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // body tables: {mass, pos_z, pos_y, pos_x} and {vel_z, vel_y, vel_x}
  pcvr_ram #(.Width(POS_W), .Depth(BODY_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (job_i.idx_a),
    .wdata_i ({job_i.mass, job_i.pos_z, job_i.pos_y, job_i.pos_x}),
    .raddr_i (raddr),
    .rdata_o (pos_rdata)
  );

  pcvr_ram #(.Width(VEL_W), .Depth(BODY_COUNT)) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (vel_we),
    .waddr_i (vel_waddr),
    .wdata_i (vel_wdata),
    .raddr_i (raddr),
    .rdata_o (vel_rdata)
  );

  pcvr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign job_pop_o = (state_q == S_IDLE) && job_valid_i;
  assign pos_we    = job_pop_o && (job_i.op == CMD_WRITE);
  assign raddr     = (state_q == S_RDA) ? idx_b_q : job_i.idx_a;
  // a read passes through S_WBB only to load the result; write nothing back
  assign vel_we    = pos_we || (state_q == S_WBA) || ((state_q == S_WBB) && !is_read_q);

  always_comb begin
    case (state_q)
      S_WBA: begin
        vel_waddr = idx_a_q;
        vel_wdata = {res_a_q[2], res_a_q[1], res_a_q[0]};
      end
      S_WBB: begin
        vel_waddr = idx_b_q;
        vel_wdata = {res_b_q[2], res_b_q[1], res_b_q[0]};
      end
      default: begin
        vel_waddr = job_i.idx_a;
        vel_wdata = {job_i.vel_z, job_i.vel_y, job_i.vel_x};
      end
    endcase
  end

  // scaled normal and datapath terms
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ds[i] = neg_q[i] ? -$signed(mag_q[i][16:0]) : $signed(mag_q[i][16:0]);
    end
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  assign one_e   = 18'(ONE_Q16) + 18'(restitution_i);
  assign wds     = w_q[cnt_q] * ds[cnt_q];
  assign ds2     = ds[cnt_q] * ds[cnt_q];
  assign g_abs   = g_q[52] ? 53'(-g_q) : 53'(g_q);
  assign qmag    = $signed({1'b0, div_quo[30:0]});
  assign qds_adj = qds_q + (qds_q[48] ? 49'sd4095 : 49'sd0);
  assign dl      = qds_adj[47:12];
  assign pa_adj  = pa_prod_q + (pa_prod_q[62] ? 63'sd16777215 : 63'sd0);
  assign pb_adj  = pb_prod_q + (pb_prod_q[62] ? 63'sd16777215 : 63'sd0);
  assign na      = 40'(va_q[cnt_q]) + 40'($signed(pa_adj[62:24]));
  assign nb      = 40'(vb_q[cnt_q]) - 40'($signed(pb_adj[62:24]));
  assign ca      = clip_f(na);
  assign cb      = clip_f(nb);

  // divider operand select: normal projection, then the two mass factors
  always_comb begin
    div_start = 1'b0;
    div_num   = {g_abs[51:0], 12'd0};
    div_den   = dd_q;
    case (state_q)
      S_QS: div_start = 1'b1;
      S_QW: begin
        div_start = div_done;
        div_num   = 64'({prod_a_q, 8'd0});
        div_den   = {1'b0, msum_q};
      end
      S_AW: begin
        div_start = div_done;
        div_num   = 64'({prod_b_q, 8'd0});
        div_den   = {1'b0, msum_q};
      end
      default: div_start = 1'b0;
    endcase
  end

  assign out_state = (state_q == S_BW) && 1'b0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            CMD_READ:    state_d = S_RDV;
            CMD_RESOLVE: state_d = S_RDA;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_RDV:  state_d = S_WBB;
      S_RDA:  state_d = S_RDB;
      S_RDB:  state_d = S_PREP;
      S_PREP: state_d = S_NORM;
      S_NORM: begin
        if (mx == '0 || msum_q == '0) begin
          state_d = S_WBA;
        end else if (mx[32:16] == '0 && mx[15]) begin
          state_d = S_DOT;
        end
      end
      S_DOT:  state_d = (cnt_q == 2'd2) ? S_QS : S_DOT;
      S_QS:   state_d = S_QW;
      S_QW:   state_d = div_done ? S_AW : S_QW;
      S_AW:   state_d = div_done ? S_BW : S_AW;
      S_BW:   state_d = div_done ? S_M1 : S_BW;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = (cnt_q == 2'd2) ? S_WBA : S_M1;
      S_WBA:  state_d = S_WBB;
      S_WBB:  state_d = (!res_valid_q || res_ready_i) ? S_IDLE : S_WBB;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_WBB) && (!res_valid_q || res_ready_i)) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i || out_state) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_a_q   <= job_i.idx_a;
        idx_b_q   <= job_i.idx_b;
        is_read_q <= (job_i.op == CMD_READ);
      end
      S_RDV: begin
        res_a_q[0] <= vel_rdata[31:0];
        res_a_q[1] <= vel_rdata[63:32];
        res_a_q[2] <= vel_rdata[95:64];
        for (int i = 0; i < 3; i++) begin
          res_b_q[i] <= '0;
        end
        sat_q <= 1'b0;
      end
      S_RDA: begin
        for (int i = 0; i < 3; i++) begin
          pa_q[i] <= pos_rdata[32*i +: 32];
          va_q[i] <= vel_rdata[32*i +: 32];
        end
        ma_q <= pos_rdata[127:96];
      end
      S_RDB: begin
        for (int i = 0; i < 3; i++) begin
          pb_q[i] <= pos_rdata[32*i +: 32];
          vb_q[i] <= vel_rdata[32*i +: 32];
        end
        mb_q <= pos_rdata[127:96];
      end
      S_PREP: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [32:0] d;
          d          = 33'(pb_q[i]) - 33'(pa_q[i]);
          neg_q[i]   <= d[32];
          mag_q[i]   <= d[32] ? 33'(-d) : 33'(d);
          w_q[i]     <= 33'(vb_q[i]) - 33'(va_q[i]);
          res_a_q[i] <= va_q[i];
          res_b_q[i] <= vb_q[i];
        end
        msum_q   <= 33'(ma_q) + 33'(mb_q);
        prod_a_q <= mb_q * one_e;
        prod_b_q <= ma_q * one_e;
        sat_q    <= 1'b0;
      end
      S_NORM: begin
        // one bit per cycle until the largest component lands in [2^15, 2^16)
        for (int i = 0; i < 3; i++) begin
          if (mx[32:16] != '0) begin
            mag_q[i] <= mag_q[i] >> 1;
          end else if (!mx[15]) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end
        cnt_q <= '0;
        g_q   <= '0;
        dd_q  <= '0;
      end
      S_DOT: begin
        g_q   <= g_q + 53'(wds);
        dd_q  <= dd_q + 34'(ds2);
        cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
      end
      S_QW: begin
        if (div_done) begin
          q_q <= g_q[52] ? -qmag : qmag;
        end
      end
      S_AW: begin
        if (div_done) begin
          fa_q <= div_quo[25:0];
        end
      end
      S_BW: begin
        if (div_done) begin
          fb_q <= div_quo[25:0];
        end
      end
      S_M1: qds_q <= q_q * ds[cnt_q];
      S_M2: begin
        pa_prod_q <= dl * $signed({1'b0, fa_q});
        pb_prod_q <= dl * $signed({1'b0, fb_q});
      end
      S_M3: begin
        res_a_q[cnt_q] <= ca[31:0];
        res_b_q[cnt_q] <= cb[31:0];
        sat_q          <= sat_q | ca[32] | cb[32];
        cnt_q          <= cnt_q + 2'd1;
      end
      default: begin
      end
    endcase
  end

  // result register, loaded in S_WBB once the previous result is taken or none is held
  always_ff @(posedge clk_i) begin
    if ((state_q == S_WBB) && (!res_valid_q || res_ready_i)) begin
      res_q.a_x <= res_a_q[0];
      res_q.a_y <= res_a_q[1];
      res_q.a_z <= res_a_q[2];
      res_q.b_x <= res_b_q[0];
      res_q.b_y <= res_b_q[1];
      res_q.b_z <= res_b_q[2];
      res_q.sat <= sat_q;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  `PCVR_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_start, !div_busy)
  `PCVR_ASSERT_IMP(a_pop_only_idle, clk_i, rst_ni, job_pop_o, state_q == S_IDLE)
  `PCVR_ASSERT_NXT(a_load_sets_valid, clk_i, rst_ni, (state_q == S_WBB) && (!res_valid_q || res_ready_i), res_valid_q && (state_q == S_IDLE))
  `PCVR_ASSERT_IMP(a_done_in_wait, clk_i, rst_ni, div_done, (state_q == S_QW) || (state_q == S_AW) || (state_q == S_BW))
endmodule

### hdl/pairwise_collision_velocity_resolver_core.sv
// Top level of the pairwise collision velocity resolver
//
// Channels: in_i carries one command beat (write body, resolve pair, read
// velocity; code 3 is taken and dropped). out_o carries one result beat per
// read or resolve. Both are valid/ready; a beat moves when both are high.
// The restitution register (unsigned Q1.16, reset 1.0) sits at APB byte
// address 0; write it only while the block is idle. pready is always high.
// A write goes to both body tables as the back end pops it; a read passes
// S_RDV and S_WBB to reach the result beat. A resolve scales the normal
// into [2^15, 2^16) and uses the shared radix-2 divider three times
// (projection and both mass factors) unless the normal or mass sum is zero.
// Throughput is one item at a time in the back end; a two-beat queue in the
// front keeps taking commands while the back end works.
// Reset clears control state and the queue; body tables hold no reset value
// and must be written before they are read.
// A stalled receiver holds the result register; the back end then waits
// with its next result, and the input stalls once the queue is full.
module pairwise_collision_velocity_resolver_core import pcvr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcvr_in_if.sink     in_i,
  pcvr_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [REST_W-1:0] restitution_q;
  logic              reg_sel;
  job_t              job;
  logic              job_valid, job_pop;
  res_t              res;

  // single register at word 0
  assign reg_sel = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(restitution_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= REST_W'(ONE_Q16);
    end else if (psel && penable && pwrite && reg_sel) begin
      restitution_q <= pwdata[REST_W-1:0];
    end
  end

  pcvr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_pop_i   (job_pop)
  );

  pcvr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .job_valid_i   (job_valid),
    .job_pop_o     (job_pop),
    .restitution_i (restitution_q),
    .res_o         (res),
    .res_valid_o   (out_o.valid),
    .res_ready_i   (out_o.ready)
  );

  assign out_o.new_vel_a_x = res.a_x;
  assign out_o.new_vel_a_y = res.a_y;
  assign out_o.new_vel_a_z = res.a_z;
  assign out_o.new_vel_b_x = res.b_x;
  assign out_o.new_vel_b_y = res.b_y;
  assign out_o.new_vel_b_z = res.b_z;
  assign out_o.saturated   = res.sat;
endmodule
